// ===== rtl/tcd_pkg.sv =====
`timescale 1ns / 1ps
package tcd_pkg;

   // Color kinds, shared by the request, the response and the support register
   localparam logic [1:0] KIND_DEFAULT = 2'd0;
   localparam logic [1:0] KIND_BASIC   = 2'd1;
   localparam logic [1:0] KIND_PALETTE = 2'd2;
   localparam logic [1:0] KIND_TRUE    = 2'd3;

   // Register map (index = byte address / 8)
   localparam int         CSR_ADDR_W        = 6;
   localparam int         CSR_DATA_W        = 64;
   localparam int         CSR_INDEX_W       = 3;
   localparam logic [2:0] REG_COLOR_SUPPORT = 3'd0;
   localparam logic [2:0] REG_RGB_WORD0     = 3'd1;
   localparam logic [2:0] REG_RGB_WORD5     = 3'd6;
   localparam int         NUM_RGB_WORDS     = 6;
   localparam logic [1:0] SUPPORT_RESET     = KIND_TRUE;

   localparam int NUM_BASIC = 16;
   localparam int DIST_W    = 18;

   // Palette layout
   localparam logic [7:0] CUBE_BASE  = 8'd16;
   localparam logic [7:0] GRAY_BASE  = 8'd232;
   localparam logic [7:0] GRAY_LOW   = 8'd8;
   localparam logic [7:0] GRAY_HIGH  = 8'd248;
   localparam logic [7:0] CUBE_WHITE = 8'd231;
   localparam logic [7:0] GRAY_STEP  = 8'd10;
   // x / 10 == (x * 205) >> 11 for x up to 240
   localparam logic [7:0] DIV10_MUL  = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   typedef logic [7:0]          chan_type;
   typedef logic [DIST_W-1:0]   dist_type;
   typedef logic [3:0]          entry_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] basic;
      logic       bright;
      chan_type   index;
      rgb_type    rgb;
   } color_type;

   // Cube coordinate of one component (thresholds 48, 115, 155, 195, 235)
   function automatic logic [2:0] cube_step(input chan_type v);
      logic [2:0] s;
      if (v < 8'd48)       s = 3'd0;
      else if (v < 8'd115) s = 3'd1;
      else if (v < 8'd155) s = 3'd2;
      else if (v < 8'd195) s = 3'd3;
      else if (v < 8'd235) s = 3'd4;
      else                 s = 3'd5;
      return s;
   endfunction

   function automatic chan_type cube_level(input logic [2:0] d);
      chan_type lv;
      case (d)
         3'd0:    lv = 8'd0;
         3'd1:    lv = 8'd95;
         3'd2:    lv = 8'd135;
         3'd3:    lv = 8'd175;
         3'd4:    lv = 8'd215;
         default: lv = 8'd255;
      endcase
      return lv;
   endfunction

   // Split a cube offset (0..215) into its three base-6 digits
   function automatic logic [8:0] cube_digits(input chan_type a);
      logic [2:0] q1;
      logic [2:0] q2;
      chan_type   rem1;
      chan_type   rem2;
      if (a >= 8'd180)      q1 = 3'd5;
      else if (a >= 8'd144) q1 = 3'd4;
      else if (a >= 8'd108) q1 = 3'd3;
      else if (a >= 8'd72)  q1 = 3'd2;
      else if (a >= 8'd36)  q1 = 3'd1;
      else                  q1 = 3'd0;
      rem1 = a - 8'({5'b0, q1} * 8'd36);
      if (rem1 >= 8'd30)      q2 = 3'd5;
      else if (rem1 >= 8'd24) q2 = 3'd4;
      else if (rem1 >= 8'd18) q2 = 3'd3;
      else if (rem1 >= 8'd12) q2 = 3'd2;
      else if (rem1 >= 8'd6)  q2 = 3'd1;
      else                    q2 = 3'd0;
      rem2 = rem1 - 8'({5'b0, q2} * 8'd6);
      return {q1, q2, rem2[2:0]};
   endfunction

   // Truecolor to a 256-color palette entry
   function automatic chan_type to_palette(input rgb_type c);
      chan_type    off;
      logic [15:0] prod;
      logic [8:0]  gray;
      chan_type    idx;
      off  = c.red - GRAY_LOW;
      prod = {8'b0, off} * {8'b0, DIV10_MUL};
      gray = {1'b0, GRAY_BASE} + {4'b0, prod[15:DIV10_SHIFT]};
      if (c.red == c.green && c.green == c.blue) begin
         if (c.red < GRAY_LOW)       idx = CUBE_BASE;
         else if (c.red > GRAY_HIGH) idx = CUBE_WHITE;
         else if (gray[8])           idx = 8'hFF;
         else                        idx = gray[7:0];
      end else begin
         idx = CUBE_BASE
             + 8'({5'b0, cube_step(c.red)} * 8'd36)
             + 8'({5'b0, cube_step(c.green)} * 8'd6)
             + {5'b0, cube_step(c.blue)};
      end
      return idx;
   endfunction

   function automatic dist_type sq_dist(input rgb_type a, input rgb_type b);
      chan_type dr;
      chan_type dg;
      chan_type db;
      dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
      dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
      db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
      return DIST_W'({8'b0, dr} * {8'b0, dr})
           + DIST_W'({8'b0, dg} * {8'b0, dg})
           + DIST_W'({8'b0, db} * {8'b0, db});
   endfunction

endpackage

// ===== rtl/terminal_color_degrader.sv =====
// Terminal color degrader: lowers one terminal color per transaction (default,
// basic 16, 256-entry palette or truecolor) to the support level held in the
// color_support register. Colors at or below that level pass through with only
// the fields of their kind kept; truecolor lowered to the palette goes to the
// gray ramp or the 6x6x6 cube; truecolor or palette lowered to basic picks the
// nearest of the 16 programmable table colors by squared RGB distance, lowest
// entry on a tie; every other lowering gives the default color. The block takes
// one transaction per cycle while the response side does not stall, and passes
// each one through these stages in order: an input register, a stage that
// resolves the palette and cube colors, a stage of 16 distance lanes, and two
// stages of the minimum tree that ends in the output register. Each stage holds
// while the one after it is full and stalled, so bubbles close up under back
// pressure. Registers sit on an APB-style port at byte address 8 * index and
// must only be written while no transaction is in flight.
`timescale 1ns / 1ps
module terminal_color_degrader
   import tcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_color_kind,
   input  logic [2:0]            req_basic_color,
   input  logic                  req_bright,
   input  logic [7:0]            req_palette_index,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind_out,
   output logic [2:0]            rsp_basic_out,
   output logic                  rsp_bright_out,
   output logic [7:0]            rsp_index_out,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   logic [1:0]             color_support_ff;
   logic [CSR_DATA_W-1:0]  rgb_word_ff [NUM_RGB_WORDS];
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_INDEX_W-1:0] word_sel;
   logic                   csr_write;
   logic                   word_hit;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_INDEX_W];
   assign word_sel   = csr_index - REG_RGB_WORD0;
   assign word_hit   = (csr_index >= REG_RGB_WORD0) && (csr_index <= REG_RGB_WORD5);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_support_ff <= SUPPORT_RESET;
         for (int k = 0; k < NUM_RGB_WORDS; k++) begin
            rgb_word_ff[k] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index == REG_COLOR_SUPPORT) begin
            color_support_ff <= csr_pwdata[1:0];
         end else if (word_hit) begin
            rgb_word_ff[word_sel] <= csr_pwdata;
         end
      end
   end

   always_comb begin
      unique case (csr_index) inside
         REG_COLOR_SUPPORT: begin
            csr_prdata = {{(CSR_DATA_W-2){1'b0}}, color_support_ff};
         end
         [REG_RGB_WORD0:REG_RGB_WORD5]: begin
            csr_prdata = rgb_word_ff[word_sel];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // Unpack the 48-byte table: entry i holds r, g, b in bytes 3i .. 3i+2
   logic [NUM_RGB_WORDS*CSR_DATA_W-1:0] table_bits;
   rgb_type                             basic_rgb [NUM_BASIC];

   always_comb begin
      for (int k = 0; k < NUM_RGB_WORDS; k++) begin
         table_bits[k*CSR_DATA_W +: CSR_DATA_W] = rgb_word_ff[k];
      end
      for (int i = 0; i < NUM_BASIC; i++) begin
         basic_rgb[i].red   = table_bits[24*i +: 8];
         basic_rgb[i].green = table_bits[24*i + 8 +: 8];
         basic_rgb[i].blue  = table_bits[24*i + 16 +: 8];
      end
   end

   // ---------------------------------------------------------------------
   // Stage handshake: a stage loads when it is empty or its content moves on
   // ---------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic a_load, b_load, c_load, d_load, e_load;

   assign e_load    = !e_valid_ff || rsp_ready;
   assign d_load    = !d_valid_ff || e_load;
   assign c_load    = !c_valid_ff || d_load;
   assign b_load    = !b_valid_ff || c_load;
   assign a_load    = !a_valid_ff || b_load;
   assign req_ready = a_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (a_load) a_valid_ff <= req_valid;
         if (b_load) b_valid_ff <= a_valid_ff;
         if (c_load) c_valid_ff <= b_valid_ff;
         if (d_load) d_valid_ff <= c_valid_ff;
         if (e_load) e_valid_ff <= d_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: capture the incoming transaction
   // ---------------------------------------------------------------------
   color_type a_color_ff;
   color_type a_color_in;

   always_comb begin
      a_color_in.kind      = req_color_kind;
      a_color_in.basic     = req_basic_color;
      a_color_in.bright    = req_bright;
      a_color_in.index     = req_palette_index;
      a_color_in.rgb.red   = req_red;
      a_color_in.rgb.green = req_green;
      a_color_in.rgb.blue  = req_blue;
   end

   always_ff @(posedge clock) begin
      if (a_load) a_color_ff <= a_color_in;
   end

   // ---------------------------------------------------------------------
   // Stage B: decide the lowering, build the direct result, and resolve
   // the RGB that the nearest-basic search compares against
   // ---------------------------------------------------------------------
   color_type  b_color_ff, b_color_in;
   logic       b_search_ff, b_search_in;
   rgb_type    b_target_ff, b_target_in;
   chan_type   cube_off;
   chan_type   gray_off;
   chan_type   gray_lv;
   logic [8:0] digits;

   assign cube_off = a_color_ff.index - CUBE_BASE;
   assign gray_off = a_color_ff.index - GRAY_BASE;
   assign gray_lv  = GRAY_LOW + 8'(gray_off * GRAY_STEP);
   assign digits   = cube_digits(cube_off);

   always_comb begin
      b_color_in  = '0;
      b_search_in = 1'b0;

      if (a_color_ff.kind <= color_support_ff) begin
         // Supported kind: keep only the fields of that kind
         b_color_in.kind = a_color_ff.kind;
         case (a_color_ff.kind)
            KIND_BASIC: begin
               b_color_in.basic  = a_color_ff.basic;
               b_color_in.bright = a_color_ff.bright;
            end
            KIND_PALETTE: begin
               b_color_in.index = a_color_ff.index;
            end
            KIND_TRUE: begin
               b_color_in.rgb = a_color_ff.rgb;
            end
            default: begin
            end
         endcase
      end else if (a_color_ff.kind == KIND_TRUE && color_support_ff == KIND_PALETTE) begin
         b_color_in.kind  = KIND_PALETTE;
         b_color_in.index = to_palette(a_color_ff.rgb);
      end else if ((a_color_ff.kind == KIND_TRUE || a_color_ff.kind == KIND_PALETTE)
                   && color_support_ff == KIND_BASIC) begin
         // Basic and bright get filled in once the search finishes
         b_color_in.kind = KIND_BASIC;
         b_search_in     = 1'b1;
      end

      // Target color: palette entries expand through table, cube or gray ramp
      if (a_color_ff.kind != KIND_PALETTE) begin
         b_target_in = a_color_ff.rgb;
      end else if (a_color_ff.index < CUBE_BASE) begin
         b_target_in = basic_rgb[a_color_ff.index[3:0]];
      end else if (a_color_ff.index < GRAY_BASE) begin
         b_target_in.red   = cube_level(digits[8:6]);
         b_target_in.green = cube_level(digits[5:3]);
         b_target_in.blue  = cube_level(digits[2:0]);
      end else begin
         b_target_in.red   = gray_lv;
         b_target_in.green = gray_lv;
         b_target_in.blue  = gray_lv;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_color_ff  <= b_color_in;
         b_search_ff <= b_search_in;
         b_target_ff <= b_target_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: one distance lane per table entry
   // ---------------------------------------------------------------------
   color_type c_color_ff;
   logic      c_search_ff;
   dist_type  c_dist_ff [NUM_BASIC];
   dist_type  c_dist_in [NUM_BASIC];

   always_comb begin
      for (int i = 0; i < NUM_BASIC; i++) begin
         c_dist_in[i] = sq_dist(b_target_ff, basic_rgb[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_color_ff  <= b_color_ff;
         c_search_ff <= b_search_ff;
         for (int i = 0; i < NUM_BASIC; i++) begin
            c_dist_ff[i] <= c_dist_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: two tree levels, 16 lanes down to 4. The left side wins on
   // equal distance, which keeps the lowest entry on a tie.
   // ---------------------------------------------------------------------
   color_type d_color_ff;
   logic      d_search_ff;
   dist_type  d_dist_ff [NUM_BASIC/4];
   entry_type d_entry_ff [NUM_BASIC/4];
   dist_type  l1_dist [NUM_BASIC/2];
   entry_type l1_entry [NUM_BASIC/2];
   dist_type  d_dist_in [NUM_BASIC/4];
   entry_type d_entry_in [NUM_BASIC/4];

   always_comb begin
      for (int j = 0; j < NUM_BASIC/2; j++) begin
         if (c_dist_ff[2*j] <= c_dist_ff[2*j+1]) begin
            l1_dist[j]  = c_dist_ff[2*j];
            l1_entry[j] = entry_type'(2*j);
         end else begin
            l1_dist[j]  = c_dist_ff[2*j+1];
            l1_entry[j] = entry_type'(2*j+1);
         end
      end
      for (int j = 0; j < NUM_BASIC/4; j++) begin
         if (l1_dist[2*j] <= l1_dist[2*j+1]) begin
            d_dist_in[j]  = l1_dist[2*j];
            d_entry_in[j] = l1_entry[2*j];
         end else begin
            d_dist_in[j]  = l1_dist[2*j+1];
            d_entry_in[j] = l1_entry[2*j+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         d_color_ff  <= c_color_ff;
         d_search_ff <= c_search_ff;
         for (int j = 0; j < NUM_BASIC/4; j++) begin
            d_dist_ff[j]  <= d_dist_in[j];
            d_entry_ff[j] <= d_entry_in[j];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage E: last two tree levels into the output register
   // ---------------------------------------------------------------------
   color_type e_color_ff, e_color_in;
   dist_type  l3_dist [2];
   entry_type l3_entry [2];
   entry_type best_entry;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         if (d_dist_ff[2*j] <= d_dist_ff[2*j+1]) begin
            l3_dist[j]  = d_dist_ff[2*j];
            l3_entry[j] = d_entry_ff[2*j];
         end else begin
            l3_dist[j]  = d_dist_ff[2*j+1];
            l3_entry[j] = d_entry_ff[2*j+1];
         end
      end
      best_entry = (l3_dist[0] <= l3_dist[1]) ? l3_entry[0] : l3_entry[1];

      e_color_in = d_color_ff;
      if (d_search_ff) begin
         // Entries 8..15 are the bright half of the basic set
         e_color_in.basic  = best_entry[2:0];
         e_color_in.bright = best_entry[3];
      end
   end

   always_ff @(posedge clock) begin
      if (e_load) e_color_ff <= e_color_in;
   end

   assign rsp_valid      = e_valid_ff;
   assign rsp_kind_out   = e_color_ff.kind;
   assign rsp_basic_out  = e_color_ff.basic;
   assign rsp_bright_out = e_color_ff.bright;
   assign rsp_index_out  = e_color_ff.index;
   assign rsp_red_out    = e_color_ff.rgb.red;
   assign rsp_green_out  = e_color_ff.rgb.green;
   assign rsp_blue_out   = e_color_ff.rgb.blue;

endmodule
